// ===== hw/rtl/optimal_bst_cost_defines.svh =====
// Assertion macros shared by the checker of the optimal search tree cost block.
`ifndef OPTIMAL_BST_COST_DEFINES_SVH
`define OPTIMAL_BST_COST_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define OBST_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("optimal_bst_cost check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define OBST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("optimal_bst_cost check failed");

`endif

// ===== hw/rtl/obst_pkg.sv =====
// Package with the sizes, states and control bundle of the optimal search tree cost block.
package obst_pkg;

  localparam int MAX_KEYS    = 32;
  localparam int WEIGHT_BITS = 16;
  localparam int SIDE        = MAX_KEYS + 1;
  localparam int CELLS       = SIDE * SIDE;
  localparam int IDX_W       = $clog2(SIDE + 1);
  localparam int ADDR_W      = $clog2(CELLS + SIDE);
  localparam int SUM_W       = WEIGHT_BITS + $clog2(2 * SIDE);
  localparam int COST_W      = 40;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_FINAL,
    ST_FETCH,
    ST_RESULT
  } obst_state_t;

  typedef struct packed {
    logic             load_we;
    logic             load_last;
    logic             cell_start;
    logic             cost_rd;
    logic             pair_rd;
    logic             scan_acc;
    logic             first;
    logic             final_we;
    logic             take_result;
    logic             overflow;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] r;
  } obst_ctrl_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(SIDE) + ADDR_W'(col);
  endfunction

endpackage

// ===== hw/rtl/obst_in_if.sv =====
// Input channel interface carrying one problem item.
interface obst_in_if;
  logic                             valid;
  logic                             ready;
  logic [obst_pkg::WEIGHT_BITS-1:0] miss_weight;
  logic [obst_pkg::WEIGHT_BITS-1:0] hit_weight;
  logic                             last_item;

  modport source (output valid, output miss_weight, output hit_weight, output last_item,
                  input ready);
  modport sink (input valid, input miss_weight, input hit_weight, input last_item,
                output ready);
endinterface

// ===== hw/rtl/obst_out_if.sv =====
// Output channel interface carrying one result item.
interface obst_out_if;
  logic                        valid;
  logic                        ready;
  logic [obst_pkg::COST_W-1:0] min_cost;
  logic                        overflow;

  modport source (output valid, output min_cost, output overflow, input ready);
  modport sink (input valid, input min_cost, input overflow, output ready);
endinterface

// ===== hw/rtl/obst_seq.sv =====
// Sequencer that loads items and walks the cost table cell by cell.
module obst_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic                 in_last,
  input  logic                 out_free,
  output logic                 in_ready,
  output obst_pkg::obst_ctrl_t ctrl
);

  obst_pkg::obst_state_t         state, state_next;
  logic [obst_pkg::IDX_W-1:0]    k, k_next;
  logic [obst_pkg::IDX_W-1:0]    n, n_next;
  logic [obst_pkg::IDX_W-1:0]    i, i_next;
  logic [obst_pkg::IDX_W-1:0]    j, j_next;
  logic [obst_pkg::IDX_W-1:0]    r, r_next;
  logic [obst_pkg::IDX_W-1:0]    dn;
  logic                          first, first_next;
  logic                          ovf, ovf_next;

  assign dn = j - i + obst_pkg::IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= obst_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= '0;
      n     <= '0;
      i     <= '0;
      j     <= '0;
      r     <= '0;
      first <= 1'b0;
      ovf   <= 1'b0;
    end else begin
      k     <= k_next;
      n     <= n_next;
      i     <= i_next;
      j     <= j_next;
      r     <= r_next;
      first <= first_next;
      ovf   <= ovf_next;
    end
  end

  always_comb begin
    state_next    = state;
    k_next        = k;
    n_next        = n;
    i_next        = i;
    j_next        = j;
    r_next        = r;
    first_next    = first;
    ovf_next      = ovf;
    in_ready      = 1'b0;
    ctrl          = '0;
    ctrl.k        = k;
    ctrl.i        = i;
    ctrl.j        = j;
    ctrl.r        = r;
    ctrl.first    = first;
    ctrl.overflow = ovf;
    case (state)
      obst_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (!in_last) begin
            if (k < obst_pkg::IDX_W'(obst_pkg::MAX_KEYS)) begin
              ctrl.load_we = 1'b1;
              k_next       = k + obst_pkg::IDX_W'(1);
            end else begin
              ovf_next = 1'b1;
            end
          end else begin
            ctrl.load_we   = 1'b1;
            ctrl.load_last = 1'b1;
            n_next         = k;
            k_next         = '0;
            i_next         = '0;
            j_next         = obst_pkg::IDX_W'(1);
            if (k == '0) begin
              state_next = obst_pkg::ST_FETCH;
            end else begin
              state_next = obst_pkg::ST_START;
            end
          end
        end
      end
      obst_pkg::ST_START: begin
        ctrl.cell_start = 1'b1;
        ctrl.cost_rd    = 1'b1;
        ctrl.pair_rd    = 1'b1;
        ctrl.r          = i;
        r_next          = i + obst_pkg::IDX_W'(1);
        first_next      = 1'b1;
        state_next      = obst_pkg::ST_SCAN;
      end
      obst_pkg::ST_SCAN: begin
        ctrl.scan_acc = 1'b1;
        first_next    = 1'b0;
        if (r != j) begin
          ctrl.cost_rd = 1'b1;
          ctrl.pair_rd = 1'b1;
          r_next       = r + obst_pkg::IDX_W'(1);
        end else begin
          state_next = obst_pkg::ST_FINAL;
        end
      end
      obst_pkg::ST_FINAL: begin
        ctrl.final_we = 1'b1;
        if (j != n) begin
          i_next     = i + obst_pkg::IDX_W'(1);
          j_next     = j + obst_pkg::IDX_W'(1);
          state_next = obst_pkg::ST_START;
        end else if (dn > n) begin
          state_next = obst_pkg::ST_FETCH;
        end else begin
          i_next     = '0;
          j_next     = dn;
          state_next = obst_pkg::ST_START;
        end
      end
      obst_pkg::ST_FETCH: begin
        ctrl.cost_rd = 1'b1;
        ctrl.i       = '0;
        ctrl.r       = n;
        state_next   = obst_pkg::ST_RESULT;
      end
      obst_pkg::ST_RESULT: begin
        if (out_free) begin
          ctrl.take_result = 1'b1;
          ovf_next         = 1'b0;
          state_next       = obst_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = obst_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

// ===== hw/rtl/obst_datapath.sv =====
// Weight stores, cost table and the shared add and compare unit.
module obst_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  obst_pkg::obst_ctrl_t             ctrl,
  input  logic [obst_pkg::WEIGHT_BITS-1:0] miss_weight,
  input  logic [obst_pkg::WEIGHT_BITS-1:0] hit_weight,
  output logic [obst_pkg::COST_W-1:0]      cost_out
);

  logic [obst_pkg::WEIGHT_BITS-1:0] gap_mem [obst_pkg::SIDE];
  logic [obst_pkg::SUM_W-1:0]       tsum_mem [obst_pkg::SIDE];
  logic [obst_pkg::COST_W-1:0]      cost_mem [obst_pkg::CELLS];

  logic [obst_pkg::SUM_W-1:0]       running;
  logic [obst_pkg::SUM_W-1:0]       tsum_a, tsum_b;
  logic [obst_pkg::WEIGHT_BITS-1:0] gap_j;
  logic [obst_pkg::SUM_W-1:0]       wsum;
  logic [obst_pkg::COST_W-1:0]      cost_a, cost_b;
  logic [obst_pkg::COST_W-1:0]      best;

  logic [obst_pkg::COST_W-1:0]      op_a, op_b, sum;
  logic [obst_pkg::ADDR_W-1:0]      wr_addr;
  logic [obst_pkg::COST_W-1:0]      wr_data;
  logic                             wr_en;

  assign op_a    = ctrl.final_we ? best : cost_a;
  assign op_b    = ctrl.final_we ? obst_pkg::COST_W'(wsum) : cost_b;
  assign sum     = op_a + op_b;
  assign wr_en   = ctrl.load_we | ctrl.final_we;
  assign wr_addr = ctrl.load_we ? obst_pkg::cell_addr(ctrl.k, ctrl.k)
                                : obst_pkg::cell_addr(ctrl.i, ctrl.j);
  assign wr_data = ctrl.load_we ? obst_pkg::COST_W'(miss_weight) : sum;
  assign cost_out = cost_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
    end else if (ctrl.load_we) begin
      if (ctrl.load_last) begin
        running <= '0;
      end else begin
        running <= running + obst_pkg::SUM_W'(miss_weight) + obst_pkg::SUM_W'(hit_weight);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_we) begin
      gap_mem[ctrl.k]  <= miss_weight;
      tsum_mem[ctrl.k] <= running;
    end
    if (ctrl.cell_start) begin
      tsum_a <= tsum_mem[ctrl.i];
      tsum_b <= tsum_mem[ctrl.j];
      gap_j  <= gap_mem[ctrl.j];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cost_mem[wr_addr] <= wr_data;
    end
    if (ctrl.cost_rd) begin
      cost_a <= cost_mem[obst_pkg::cell_addr(ctrl.i, ctrl.r)];
    end
    if (ctrl.pair_rd) begin
      cost_b <= cost_mem[obst_pkg::cell_addr(ctrl.r + obst_pkg::IDX_W'(1), ctrl.j)];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan_acc) begin
      if (ctrl.first) begin
        wsum <= tsum_b - tsum_a + obst_pkg::SUM_W'(gap_j);
      end
      if (ctrl.first || (sum < best)) begin
        best <= sum;
      end
    end
  end

endmodule

// ===== hw/rtl/optimal_bst_cost.sv =====
// Optimal binary search tree cost block: top level with the result register.
//
// Items load one per cycle. A problem of n keys is n+1 items, the last one
// marked; extra keys past the table size are dropped and flagged. After the
// last item the input stays not ready while the dynamic program runs on one
// shared add and compare unit over the cost table: each table cell of span d
// takes a start step, a scan over its d split points and a final write, and
// the answer is then fetched from the table. The time is set by reading
// two cost table entries per split point through the table's two read ports.
// The result then moves into an output register, and loading of the next
// problem resumes while it waits to be taken.
module optimal_bst_cost (
  input  logic       clk,
  input  logic       rst,
  obst_in_if.sink    items,
  obst_out_if.source results
);

  obst_pkg::obst_ctrl_t        ctrl;
  logic                        in_fire;
  logic                        out_free;
  logic [obst_pkg::COST_W-1:0] cost_out;
  logic                        valid;
  logic [obst_pkg::COST_W-1:0] min_cost;
  logic                        overflow;

  assign in_fire  = items.valid & items.ready;
  assign out_free = ~valid | results.ready;

  obst_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_last  (items.last_item),
    .out_free (out_free),
    .in_ready (items.ready),
    .ctrl     (ctrl)
  );

  obst_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .miss_weight (items.miss_weight),
    .hit_weight  (items.hit_weight),
    .cost_out    (cost_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.take_result) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take_result) begin
      min_cost <= cost_out;
      overflow <= ctrl.overflow;
    end
  end

  assign results.valid    = valid;
  assign results.min_cost = min_cost;
  assign results.overflow = overflow;

endmodule

// ===== hw/rtl/obst_checker.sv =====
// Port level checker for the optimal search tree cost block and its bind.
`include "optimal_bst_cost_defines.svh"

module obst_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [obst_pkg::COST_W-1:0] out_cost
);

  `OBST_ASSERT_NEXT(a_run_stalls_input, clk, rst, in_valid && in_ready && in_last, !in_ready)
  `OBST_ASSERT_SAME(a_ready_drops_on_last, clk, rst, $fell(in_ready), $past(in_valid && in_last))
  `OBST_ASSERT_SAME(a_result_after_run, clk, rst, $rose(out_valid), $past(!in_ready))
  `OBST_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(out_cost))

endmodule

bind optimal_bst_cost obst_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_last   (items.last_item),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_cost  (results.min_cost)
);

// ===== tb/optimal_bst_cost_tb.sv =====
// Testbench for the optimal binary search tree cost block, with its own cost predictor.
`timescale 1ns / 100ps

module optimal_bst_cost_tb;
  import obst_pkg::*;

  localparam int ITEMS_PER_PHASE = 325;
  localparam int NUM_PHASES = 4;
  localparam int DIRECTED_ROWS = 14;
  localparam longint LIMIT_NS = 40_000_000;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] miss;
    logic [WEIGHT_BITS-1:0] hit;
    logic                   last;
    logic                   typed;
    logic [COST_W-1:0]      cost;
    logic                   ovf;
  } stim_row_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              ovf;
  } tree_result_t;

  localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 40'd0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 40'd65535, 1'b0},
    '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'hFFFF, 16'h0000, 1'b1, 1'b1, 40'd327675, 1'b0},
    '{16'h0000, 16'h0000, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 40'd0, 1'b0},
    '{16'h0001, 16'hFFFF, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'hFFFF, 16'h0001, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'hAAAA, 16'h5555, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'h5555, 16'hAAAA, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'h8000, 16'h0001, 1'b1, 1'b0, 40'd0, 1'b0},
    '{16'h0001, 16'h8000, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'h7FFF, 16'hFFFE, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'h0000, 16'h0000, 1'b1, 1'b0, 40'd0, 1'b0}
  };

  localparam int PHASE_IDLE [0:NUM_PHASES-1] = '{0, 61, 0, 18};
  localparam int PHASE_STALL [0:NUM_PHASES-1] = '{0, 0, 61, 18};

  logic clk = 1'b0;
  logic rst;

  obst_in_if items_ch ();
  obst_out_if results_ch ();

  optimal_bst_cost uut (
    .clk(clk),
    .rst(rst),
    .items(items_ch),
    .results(results_ch)
  );

  logic [WEIGHT_BITS-1:0] held_keys [0:MAX_KEYS-1];
  logic [WEIGHT_BITS-1:0] held_gaps [0:MAX_KEYS];
  int unsigned keys_held = 0;
  bit keys_dropped = 1'b0;

  tree_result_t pending_costs [$];
  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #LIMIT_NS;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [COST_W-1:0] tree_cost(input int unsigned n);
    bit [63:0] e [0:SIDE-1][0:SIDE-1];
    bit [63:0] w [0:SIDE-1][0:SIDE-1];
    bit [63:0] best;
    bit [63:0] v;
    int unsigned j;
    for (int unsigned i = 0; i <= n; i++) begin
      e[i][i] = 64'(held_gaps[i]);
      w[i][i] = 64'(held_gaps[i]);
    end
    for (int unsigned d = 1; d <= n; d++) begin
      for (int unsigned i = 0; i + d <= n; i++) begin
        j = i + d;
        w[i][j] = w[i][j-1] + 64'(held_keys[j-1]) + 64'(held_gaps[j]);
        best = e[i][i] + e[i+1][j];
        for (int unsigned r = i + 1; r < j; r++) begin
          v = e[i][r] + e[r+1][j];
          if (v < best) begin
            best = v;
          end
        end
        e[i][j] = best + w[i][j];
      end
    end
    return e[0][n][COST_W-1:0];
  endfunction

  task automatic send_item(input logic [WEIGHT_BITS-1:0] miss, input logic [WEIGHT_BITS-1:0] hit,
                           input logic last, input logic typed,
                           input logic [COST_W-1:0] typed_cost, input logic typed_ovf);
    tree_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.miss_weight <= miss;
    items_ch.hit_weight <= hit;
    items_ch.last_item <= last;
    do begin
      @(posedge clk);
    end while (!items_ch.ready);
    if (!last) begin
      if (keys_held < MAX_KEYS) begin
        held_gaps[keys_held] = miss;
        held_keys[keys_held] = hit;
        keys_held++;
      end else begin
        keys_dropped = 1'b1;
      end
    end else begin
      held_gaps[keys_held] = miss;
      res.cost = tree_cost(keys_held);
      res.ovf = keys_dropped;
      if (typed) begin
        res.cost = typed_cost;
        res.ovf = typed_ovf;
      end
      pending_costs.push_back(res);
      keys_held = 0;
      keys_dropped = 1'b0;
    end
  endtask

  function automatic logic [WEIGHT_BITS-1:0] rand_weight();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return WEIGHT_BITS'($urandom);
    endcase
  endfunction

  task automatic send_problem(input int unsigned n_keys);
    for (int unsigned k = 0; k < n_keys; k++) begin
      send_item(rand_weight(), rand_weight(), 1'b0, 1'b0, '0, 1'b0);
    end
    send_item(rand_weight(), rand_weight(), 1'b1, 1'b0, '0, 1'b0);
  endtask

  always @(posedge clk) begin
    results_ch.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    tree_result_t exp_res;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (pending_costs.size() == 0) begin
        report_mismatch($sformatf("unexpected result cost %0d overflow %0b",
                                  results_ch.min_cost, results_ch.overflow));
      end else begin
        exp_res = pending_costs.pop_front();
        if (results_ch.min_cost !== exp_res.cost) begin
          report_mismatch($sformatf("min_cost %0d, expected %0d",
                                    results_ch.min_cost, exp_res.cost));
        end
        if (results_ch.overflow !== exp_res.ovf) begin
          report_mismatch($sformatf("overflow %0b, expected %0b",
                                    results_ch.overflow, exp_res.ovf));
        end
      end
    end
  end

  initial begin
    int sent;
    int pick;
    int unsigned n_keys;
    rst <= 1'b1;
    items_ch.valid <= 1'b0;
    items_ch.miss_weight <= '0;
    items_ch.hit_weight <= '0;
    items_ch.last_item <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      send_item(DIRECTED[row].miss, DIRECTED[row].hit, DIRECTED[row].last,
                DIRECTED[row].typed, DIRECTED[row].cost, DIRECTED[row].ovf);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct = PHASE_IDLE[p];
      stall_pct = PHASE_STALL[p];
      sent = 0;
      if (p == 0) begin
        n_keys = $urandom_range(MAX_KEYS + 6, MAX_KEYS + 2);
        send_problem(n_keys);
        sent += n_keys + 1;
      end
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          n_keys = $urandom_range(6, 0);
        end else if (pick < 90) begin
          n_keys = $urandom_range(16, 7);
        end else if (pick < 96) begin
          n_keys = $urandom_range(MAX_KEYS, 17);
        end else begin
          n_keys = $urandom_range(MAX_KEYS + 6, MAX_KEYS + 1);
        end
        send_problem(n_keys);
        sent += n_keys + 1;
      end
    end

    items_ch.valid <= 1'b0;
    while (pending_costs.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_costs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== optimal_bst_cost.f =====
+incdir+hw/rtl
hw/rtl/obst_pkg.sv
hw/rtl/obst_in_if.sv
hw/rtl/obst_out_if.sv
hw/rtl/obst_seq.sv
hw/rtl/obst_datapath.sv
hw/rtl/optimal_bst_cost.sv
hw/rtl/obst_checker.sv
tb/optimal_bst_cost_tb.sv
